>>> src/aq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aq_pkg;

  localparam int QW = 34;
  localparam logic signed [QW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [QW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [QW-1:0] Q30_GAIN    = 34'sd652032874;
  localparam logic signed [QW-1:0] Q16_ROUND   = 34'sd32768;

  localparam logic [1:0] OP_EULER = 2'd0;
  localparam logic [1:0] OP_AXIS  = 2'd1;
  localparam logic [1:0] OP_RAW   = 2'd2;

  typedef logic signed [QW-1:0] q30_t;

  typedef struct packed {
    q30_t x;
    q30_t y;
    q30_t z;
  } lane_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         flip;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [15:0] raw_w;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic signed [15:0] raw_z;
  } side_t;

  function automatic q30_t atan_q30(input int i);
    q30_t r;
    unique case (i)
      0:  r = 34'sh03243F6A8;
      1:  r = 34'sh01DAC6705;
      2:  r = 34'sh00FADBAFC;
      3:  r = 34'sh007F56EA6;
      4:  r = 34'sh003FEAB76;
      5:  r = 34'sh001FFD55B;
      6:  r = 34'sh000FFFAAA;
      7:  r = 34'sh0007FFF55;
      8:  r = 34'sh0003FFFEA;
      9:  r = 34'sh0001FFFFD;
      10: r = 34'sh0000FFFFF;
      11: r = 34'sh00007FFFF;
      12: r = 34'sh00003FFFF;
      13: r = 34'sh00001FFFF;
      14: r = 34'sh00000FFFF;
      15: r = 34'sh000007FFF;
      16: r = 34'sh000003FFF;
      17: r = 34'sh000001FFF;
      18: r = 34'sh000000FFF;
      19: r = 34'sh0000007FF;
      20: r = 34'sh0000003FF;
      21: r = 34'sh0000001FF;
      22: r = 34'sh0000000FF;
      23: r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q30_t mul30(input q30_t a, input q30_t b);
    logic signed [2*QW-1:0] p;
    p = a * b + 68'sd536870912;
    return p[QW+29:30];
  endfunction

  function automatic logic signed [15:0] sat16(input q30_t v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] q30_to_out(input q30_t v);
    q30_t t;
    t = (v + Q16_ROUND) >>> 16;
    return sat16(t);
  endfunction

endpackage
`default_nettype wire

>>> src/aq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module aq_cell #(
  parameter int STEP = 0
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  aq_pkg::side_t           in_side,
  input  aq_pkg::lane_t [2:0]     in_lane,
  output logic                    out_valid,
  output aq_pkg::side_t           out_side,
  output aq_pkg::lane_t [2:0]     out_lane
);
  import aq_pkg::*;

  localparam q30_t ATAN = atan_q30(STEP);

  lane_t [2:0] lane_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (!in_lane[k].z[QW-1]) begin
        lane_next[k].x = in_lane[k].x - (in_lane[k].y >>> STEP);
        lane_next[k].y = in_lane[k].y + (in_lane[k].x >>> STEP);
        lane_next[k].z = in_lane[k].z - ATAN;
      end else begin
        lane_next[k].x = in_lane[k].x + (in_lane[k].y >>> STEP);
        lane_next[k].y = in_lane[k].y - (in_lane[k].x >>> STEP);
        lane_next[k].z = in_lane[k].z + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_side <= in_side;
    out_lane <= lane_next;
  end

endmodule
`default_nettype wire

>>> src/aq_combine.sv
`timescale 1ns / 1ps
`default_nettype none
module aq_combine (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  input  aq_pkg::side_t           in_side,
  input  aq_pkg::lane_t [2:0]     in_lane,
  output logic                    done,
  output logic signed [15:0]      quat_w,
  output logic signed [15:0]      quat_x,
  output logic signed [15:0]      quat_y,
  output logic signed [15:0]      quat_z
);
  import aq_pkg::*;

  // stage 1: undo range reduction
  logic  v1, v2, v3;
  side_t s1, s2, s3;
  q30_t  ca, cb, cc, sa, sb, sc, s0;
  // stage 2: pair products
  q30_t  cacb, sasb, sacb, casb, c0, px, py, pz;
  q30_t  ccd, scd;
  // stage 3: triple products
  q30_t  t0, t1, t2, t3, t4, t5, t6, t7;
  q30_t  c0d, pxd, pyd, pzd;
  logic signed [15:0] w_next, x_next, y_next, z_next;

  function automatic q30_t fix(input q30_t v, input logic f);
    return f ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      done <= v3;
    end
    s1 <= in_side;
    ca <= fix(in_lane[0].x, in_side.flip[0]);
    cb <= fix(in_lane[1].x, in_side.flip[1]);
    cc <= fix(in_lane[2].x, in_side.flip[2]);
    s0 <= fix(in_lane[0].y, in_side.flip[0]);
    sa <= fix(in_lane[0].y, !in_side.flip[0]);
    sb <= fix(in_lane[1].y, !in_side.flip[1]);
    sc <= fix(in_lane[2].y, !in_side.flip[2]);

    s2   <= s1;
    cacb <= mul30(ca, cb);
    sasb <= mul30(sa, sb);
    sacb <= mul30(sa, cb);
    casb <= mul30(ca, sb);
    ccd  <= cc;
    scd  <= sc;
    c0   <= ca;
    px   <= mul30(q30_t'(s1.axis_x), s0);
    py   <= mul30(q30_t'(s1.axis_y), s0);
    pz   <= mul30(q30_t'(s1.axis_z), s0);

    s3  <= s2;
    t0  <= mul30(cacb, ccd);
    t1  <= mul30(sasb, scd);
    t2  <= mul30(sasb, ccd);
    t3  <= mul30(cacb, scd);
    t4  <= mul30(sacb, ccd);
    t5  <= mul30(casb, scd);
    t6  <= mul30(casb, ccd);
    t7  <= mul30(sacb, scd);
    c0d <= c0;
    pxd <= px;
    pyd <= py;
    pzd <= pz;

    quat_w <= w_next;
    quat_x <= x_next;
    quat_y <= y_next;
    quat_z <= z_next;
  end

  // cc and sc are delayed one stage to line up with the pair products
  always_comb begin
    unique case (s3.op)
      OP_EULER: begin
        w_next = q30_to_out(t0 - t1);
        x_next = q30_to_out(t2 + t3);
        y_next = q30_to_out(t4 + t5);
        z_next = q30_to_out(t6 - t7);
      end
      OP_AXIS: begin
        w_next = q30_to_out(c0d);
        x_next = sat16(pxd);
        y_next = sat16(pyd);
        z_next = sat16(pzd);
      end
      OP_RAW: begin
        w_next = s3.raw_w;
        x_next = s3.raw_x;
        y_next = s3.raw_y;
        z_next = s3.raw_z;
      end
      default: begin
        w_next = '0;
        x_next = '0;
        y_next = '0;
        z_next = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/angles_to_quaternion_core.sv
// Rotation to unit quaternion converter (Euler angles, axis and angle, or raw
// quaternion passthrough). A word is taken on every clock where start is high;
// busy is always low, so one word per cycle is sustained. Each result appears
// on quat_w..quat_z for one cycle with done high, after one range-reduction
// stage, one CORDIC cell per iteration and four product/rounding stages. The
// receiver cannot stall; results must be taken when done is high.
`timescale 1ns / 1ps
`default_nettype none
module angles_to_quaternion_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         op,
  input  wire  signed [15:0] angle_alpha,
  input  wire  signed [15:0] angle_beta,
  input  wire  signed [15:0] angle_gamma,
  input  wire  signed [15:0] turn_angle,
  input  wire  signed [15:0] axis_x,
  input  wire  signed [15:0] axis_y,
  input  wire  signed [15:0] axis_z,
  input  wire  signed [15:0] raw_w,
  input  wire  signed [15:0] raw_x,
  input  wire  signed [15:0] raw_y,
  input  wire  signed [15:0] raw_z,
  output logic               done,
  output logic signed [15:0] quat_w,
  output logic signed [15:0] quat_x,
  output logic signed [15:0] quat_y,
  output logic signed [15:0] quat_z
);
  import aq_pkg::*;

  logic               chain_valid [CORDIC_STEPS+1];
  side_t              chain_side  [CORDIC_STEPS+1];
  lane_t [2:0]        chain_lane  [CORDIC_STEPS+1];

  logic signed [15:0] ang [3];
  lane_t [2:0]        lane_next;
  side_t              side_next;

  assign busy = 1'b0;

  always_comb begin
    ang[0] = (op == OP_AXIS) ? turn_angle : angle_alpha;
    ang[1] = angle_beta;
    ang[2] = angle_gamma;
    side_next.op     = op;
    side_next.axis_x = axis_x;
    side_next.axis_y = axis_y;
    side_next.axis_z = axis_z;
    side_next.raw_w  = raw_w;
    side_next.raw_x  = raw_x;
    side_next.raw_y  = raw_y;
    side_next.raw_z  = raw_z;
    for (int k = 0; k < 3; k++) begin
      q30_t z;
      z = {ang[k][15], ang[k], 17'b0};
      lane_next[k].x = Q30_GAIN;
      lane_next[k].y = '0;
      if (z > Q30_HALF_PI) begin
        lane_next[k].z = z - Q30_PI;
        side_next.flip[k] = 1'b1;
      end else if (z < -Q30_HALF_PI) begin
        lane_next[k].z = z + Q30_PI;
        side_next.flip[k] = 1'b1;
      end else begin
        lane_next[k].z = z;
        side_next.flip[k] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else begin
      chain_valid[0] <= start;
    end
    chain_side[0] <= side_next;
    chain_lane[0] <= lane_next;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    aq_cell #(.STEP(i)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_side   (chain_side[i]),
      .in_lane   (chain_lane[i]),
      .out_valid (chain_valid[i+1]),
      .out_side  (chain_side[i+1]),
      .out_lane  (chain_lane[i+1])
    );
  end

  aq_combine u_combine (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_valid[CORDIC_STEPS]),
    .in_side  (chain_side[CORDIC_STEPS]),
    .in_lane  (chain_lane[CORDIC_STEPS]),
    .done     (done),
    .quat_w   (quat_w),
    .quat_x   (quat_x),
    .quat_y   (quat_y),
    .quat_z   (quat_z)
  );

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import aq_pkg::*;

  localparam int STEPS = 16;
  localparam int LATENCY = STEPS + 5;
  localparam int N_RANDOM = 1700;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI = 64'sd3373259426;
  localparam longint GAIN = 64'sd652032874;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] op = '0;
  logic signed [15:0] angle_alpha = '0, angle_beta = '0, angle_gamma = '0;
  logic signed [15:0] turn_angle = '0, axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [15:0] raw_w = '0, raw_x = '0, raw_y = '0, raw_z = '0;
  logic busy, done;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

  angles_to_quaternion_core #(.CORDIC_STEPS(STEPS)) DUT (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return shr(a * b + 64'sd536870912, 30);
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end
    if (v < -32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] to_q14(longint v);
    return clip16(shr(v + 32768, 16));
  endfunction

  function automatic void half_cos_sin(logic signed [15:0] a, output longint c,
                                       output longint s);
    longint zz, xx, yy, dx, dy;
    bit flip;
    zz = longint'(a) * 131072;
    flip = 0;
    xx = GAIN;
    yy = 0;
    if (zz > HALF_PI) begin
      zz -= PI;
      flip = 1;
    end else if (zz < -HALF_PI) begin
      zz += PI;
      flip = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = shr(yy, i);
      dy = shr(xx, i);
      if (zz >= 0) begin
        xx -= dx;
        yy += dy;
        zz -= longint'(atan_q30(i));
      end else begin
        xx += dx;
        yy -= dy;
        zz += longint'(atan_q30(i));
      end
    end
    c = flip ? -xx : xx;
    s = flip ? -yy : yy;
  endfunction

  class quat_scoreboard;
    quat_t pending[$];
    int errors = 0;

    function void note_word(logic [1:0] o, logic signed [15:0] a, b, g, t, ax, ay,
                            az, rw, rx, ry, rz);
      quat_t q;
      longint ca, sa, cb, sb, cc, sc, c, s;
      case (o)
        OP_EULER: begin
          half_cos_sin(a, ca, sa);
          half_cos_sin(b, cb, sb);
          half_cos_sin(g, cc, sc);
          sa = -sa;
          sb = -sb;
          sc = -sc;
          q.w = to_q14(qmul(qmul(ca, cb), cc) - qmul(qmul(sa, sb), sc));
          q.x = to_q14(qmul(qmul(sa, sb), cc) + qmul(qmul(ca, cb), sc));
          q.y = to_q14(qmul(qmul(sa, cb), cc) + qmul(qmul(ca, sb), sc));
          q.z = to_q14(qmul(qmul(ca, sb), cc) - qmul(qmul(sa, cb), sc));
        end
        OP_AXIS: begin
          half_cos_sin(t, c, s);
          q.w = to_q14(c);
          q.x = clip16(qmul(longint'(ax), s));
          q.y = clip16(qmul(longint'(ay), s));
          q.z = clip16(qmul(longint'(az), s));
        end
        OP_RAW: begin
          q.w = rw;
          q.x = rx;
          q.y = ry;
          q.z = rz;
        end
        default: begin
          q.w = '0;
          q.x = '0;
          q.y = '0;
          q.z = '0;
        end
      endcase
      pending.push_back(q);
    endfunction

    function void check_word(logic signed [15:0] w, x, y, z);
      quat_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d",
                 $time, w, x, y, z);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.w !== w) begin
        $display("%0t: quat_w expected %0d actual %0d", $time, e.w, w);
        errors++;
      end
      if (e.x !== x) begin
        $display("%0t: quat_x expected %0d actual %0d", $time, e.x, x);
        errors++;
      end
      if (e.y !== y) begin
        $display("%0t: quat_y expected %0d actual %0d", $time, e.y, y);
        errors++;
      end
      if (e.z !== z) begin
        $display("%0t: quat_z expected %0d actual %0d", $time, e.z, z);
        errors++;
      end
    endfunction
  endclass

  quat_scoreboard sb = new();
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note_word(op, angle_alpha, angle_beta, angle_gamma, turn_angle, axis_x,
                     axis_y, axis_z, raw_w, raw_x, raw_y, raw_z);
      end
      if (done) begin
        sb.check_word(quat_w, quat_x, quat_y, quat_z);
      end
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  bit no_gaps = 0;

  task automatic send_word(logic [1:0] o, logic signed [15:0] a, b, g, t, ax, ay,
                           az, rw, rx, ry, rz);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    angle_alpha <= a;
    angle_beta <= b;
    angle_gamma <= g;
    turn_angle <= t;
    axis_x <= ax;
    axis_y <= ay;
    axis_z <= az;
    raw_w <= rw;
    raw_x <= rx;
    raw_y <= ry;
    raw_z <= rz;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick16();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 12868)) - 16'sd6434;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send_random();
    logic [1:0] o;
    o = ($urandom_range(0, 19) == 0) ? OP_NONE : 2'($urandom_range(0, 2));
    send_word(o, pick16(), pick16(), ($urandom_range(0, 7) == 0) ? 16'sd0 : pick16(),
              pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
              pick16());
  endtask

  initial begin
    int waited;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // extremes of each mode and the undefined op
    send_word(OP_EULER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_EULER, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_EULER, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_EULER, 6434, -6434, 0, 16'sh7FFF, -1, -1, -1, -1, -1, -1, -1);
    send_word(OP_EULER, 12868, 6433, -6435, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_EULER, 6435, 6433, -1, 0, 0, 0, 0, 0, 0, 0, 0);
    send_word(OP_AXIS, -1, -1, -1, 0, 16'sh7FFF, 16'sh8000, 16384, 0, 0, 0, 0);
    send_word(OP_AXIS, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, -1, 0, 0, 0, 0);
    send_word(OP_AXIS, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh7FFF, 1, 0, 0, 0, 0);
    send_word(OP_AXIS, 0, 0, 0, 12868, 16384, 0, 0, 0, 0, 0, 0);
    send_word(OP_AXIS, 0, 0, 0, -12868, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0);
    send_word(OP_RAW, 0, 0, 0, 0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 0, -1);
    send_word(OP_RAW, -1, -1, -1, -1, -1, -1, -1, 16'sh8000, 16'sh7FFF, -1, 0);
    send_word(OP_NONE, 6434, 6434, 6434, 6434, 1, 1, 1, 1, 1, 1, 1);
    send_word(OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < N_RANDOM; i++) begin
      no_gaps = ((i / 100) % 4) == 3;
      send_random();
    end
    start <= 1'b0;
    waited = 0;
    while (sb.pending.size() != 0 && waited < 10 * LATENCY + 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.pending.size() != 0) begin
        $display("%0t: %0d words never arrived", $time, sb.pending.size());
      end
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> sim.f
src/aq_pkg.sv
src/aq_cell.sv
src/aq_combine.sv
src/angles_to_quaternion_core.sv
tb/tb.sv
